FILE: hdl/rpchdr_pkg.sv
// ----------------------------------------------------------------------------
// rpchdr_pkg
// Types and constants shared by the RPC record call header parser.
// ----------------------------------------------------------------------------
package rpchdr_pkg;

   typedef enum logic [1:0] {
      KIND_HEADER    = 2'd0,
      KIND_ARG       = 2'd1,
      KIND_ERROR     = 2'd2,
      KIND_EMPTY_END = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NOT_CALL    = 2'd0,
      ERR_BAD_VERSION = 2'd1,
      ERR_MALFORMED   = 2'd2,
      ERR_TOO_LARGE   = 2'd3
   } err_type;

   typedef enum logic {
      PH_MARKER = 1'b0,
      PH_BODY   = 1'b1
   } phase_type;

   // call header steps
   localparam logic [3:0] F_XID         = 4'd0;
   localparam logic [3:0] F_MSG_TYPE    = 4'd1;
   localparam logic [3:0] F_RPC_VERS    = 4'd2;
   localparam logic [3:0] F_PROG        = 4'd3;
   localparam logic [3:0] F_VERS        = 4'd4;
   localparam logic [3:0] F_PROC        = 4'd5;
   localparam logic [3:0] F_CRED_FLAVOR = 4'd6;
   localparam logic [3:0] F_CRED_LEN    = 4'd7;
   localparam logic [3:0] F_CRED_BODY   = 4'd8;
   localparam logic [3:0] F_VERF_FLAVOR = 4'd9;
   localparam logic [3:0] F_VERF_LEN    = 4'd10;
   localparam logic [3:0] F_VERF_BODY   = 4'd11;
   localparam logic [3:0] F_ARGS        = 4'd12;

   localparam logic [31:0] MSG_TYPE_CALL = 32'd0;
   localparam logic [31:0] RPC_VERSION   = 32'd2;

   localparam logic [30:0] MAX_RECORD_RESET = 31'd1048576;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] xid;
      logic [31:0] program_res;
      logic [31:0] prog_version;
      logic [31:0] procedure;
      logic [7:0]  arg_byte;
      logic        last;
      err_type     error_code;
   } rsp_type;

endpackage

FILE: hdl/rpchdr_parse.sv
// ----------------------------------------------------------------------------
// rpchdr_parse
// Per-byte parse state: fragment markers, record length check, call header
// fields and argument pass-through. Gives the result of the byte being taken.
// ----------------------------------------------------------------------------
module rpchdr_parse #(
   parameter int MAX_AUTH_BODY = 400
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          data_byte,
   input  logic [30:0]         max_record_bytes,
   output logic                res_valid,
   output rpchdr_pkg::rsp_type res
);
   import rpchdr_pkg::*;

   localparam int OW = $clog2(MAX_AUTH_BODY + 4);

   typedef enum logic [1:0] {
      PR_NONE  = 2'd0,
      PR_DATA  = 2'd1,
      PR_ERROR = 2'd2
   } parse_res_type;

   phase_type      phase_ff, phase_in;
   logic [23:0]    marker_shift_ff, marker_shift_in;
   logic [1:0]     marker_count_ff, marker_count_in;
   logic [30:0]    fragment_left_ff, fragment_left_in;
   logic           final_fragment_ff, final_fragment_in;
   logic [30:0]    record_total_ff, record_total_in;
   logic [23:0]    word_shift_ff, word_shift_in;
   logic [1:0]     byte_in_word_ff, byte_in_word_in;
   logic [3:0]     field_index_ff, field_index_in;
   logic [OW-1:0]  opaque_left_ff, opaque_left_in;
   logic           discarding_ff, discarding_in;
   logic [31:0]    xid_ff, xid_in;
   logic [31:0]    program_ff, program_in;
   logic [31:0]    version_ff, version_in;
   logic [31:0]    procedure_ff, procedure_in;

   logic [31:0]    marker_word;
   logic [31:0]    word;
   logic [31:0]    total_sum;
   logic [30:0]    frag_dec;
   logic [OW-1:0]  opaque_dec;
   logic [OW-1:0]  padded;
   logic [3:0]     field_next;
   logic           ends;
   logic           end_rec;
   parse_res_type  pres;
   rsp_type        hdr;
   rsp_type        pout;

   assign marker_word = {marker_shift_ff, data_byte};
   assign word        = {word_shift_ff, data_byte};
   assign total_sum   = {1'b0, record_total_ff} + {1'b0, marker_word[30:0]};
   assign frag_dec    = (fragment_left_ff != '0) ? fragment_left_ff - 31'd1 : fragment_left_ff;
   assign opaque_dec  = (opaque_left_ff != '0) ? opaque_left_ff - OW'(1) : opaque_left_ff;
   assign padded      = (word[OW-1:0] + OW'(3)) & ~OW'(3);
   assign ends        = (frag_dec == '0) && final_fragment_ff;

   always_comb begin
      hdr              = '0;
      hdr.kind         = KIND_HEADER;
      hdr.xid          = xid_ff;
      hdr.program_res  = program_ff;
      hdr.prog_version = version_ff;
      hdr.procedure    = procedure_ff;
   end

   // call header parse of one body byte
   always_comb begin
      pres            = PR_NONE;
      pout            = '0;
      field_next      = field_index_ff + 4'd1;
      word_shift_in   = word_shift_ff;
      byte_in_word_in = byte_in_word_ff;
      field_index_in  = field_index_ff;
      opaque_left_in  = opaque_left_ff;
      xid_in          = xid_ff;
      program_in      = program_ff;
      version_in      = version_ff;
      procedure_in    = procedure_ff;
      if (field_index_ff >= F_ARGS) begin
         pres          = PR_DATA;
         pout.kind     = KIND_ARG;
         pout.arg_byte = data_byte;
      end else if (field_index_ff == F_CRED_BODY || field_index_ff == F_VERF_BODY) begin
         opaque_left_in = opaque_dec;
         if (opaque_dec == '0) begin
            field_index_in = field_next;
            if (field_next == F_ARGS) begin
               pres = PR_DATA;
               pout = hdr;
            end
         end
      end else begin
         word_shift_in   = word[23:0];
         byte_in_word_in = byte_in_word_ff + 2'd1;
         if (byte_in_word_ff == 2'd3) begin
            field_index_in = field_next;
            unique case (field_index_ff) inside
               F_XID:  xid_in = word;
               F_MSG_TYPE: begin
                  if (word != MSG_TYPE_CALL) begin
                     pres            = PR_ERROR;
                     pout.error_code = ERR_NOT_CALL;
                     field_index_in  = field_index_ff;
                  end
               end
               F_RPC_VERS: begin
                  if (word != RPC_VERSION) begin
                     pres            = PR_ERROR;
                     pout.error_code = ERR_BAD_VERSION;
                     field_index_in  = field_index_ff;
                  end
               end
               F_PROG: program_in   = word;
               F_VERS: version_in   = word;
               F_PROC: procedure_in = word;
               F_CRED_LEN, F_VERF_LEN: begin
                  if (word > 32'(MAX_AUTH_BODY)) begin
                     pres            = PR_ERROR;
                     pout.error_code = ERR_MALFORMED;
                     field_index_in  = field_index_ff;
                  end else begin
                     opaque_left_in = padded;
                     if (padded == '0) begin
                        field_index_in = field_index_ff + 4'd2;
                     end
                     if (field_index_in == F_ARGS) begin
                        pres = PR_DATA;
                        pout = hdr;
                     end
                  end
               end
               default: ;
            endcase
            if (pres == PR_ERROR) begin
               pout.kind = KIND_ERROR;
               pout.last = 1'b1;
            end
         end
      end
   end

   // record and fragment control
   always_comb begin
      phase_in          = phase_ff;
      marker_shift_in   = marker_shift_ff;
      marker_count_in   = marker_count_ff;
      fragment_left_in  = fragment_left_ff;
      final_fragment_in = final_fragment_ff;
      record_total_in   = record_total_ff;
      discarding_in     = discarding_ff;
      end_rec           = 1'b0;
      res_valid         = 1'b0;
      res               = '0;
      if (phase_ff == PH_MARKER) begin
         marker_shift_in = marker_word[23:0];
         marker_count_in = marker_count_ff + 2'd1;
         if (marker_count_ff == 2'd3) begin
            marker_shift_in   = '0;
            final_fragment_in = marker_word[31];
            fragment_left_in  = marker_word[30:0];
            if (discarding_ff) begin
               if (marker_word[30:0] != '0) begin
                  phase_in = PH_BODY;
               end else if (marker_word[31]) begin
                  end_rec = 1'b1;
               end
            end else if (total_sum > {1'b0, max_record_bytes}) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.last       = 1'b1;
               res.error_code = ERR_TOO_LARGE;
               if (marker_word[30:0] == '0 && marker_word[31]) begin
                  end_rec = 1'b1;
               end else begin
                  discarding_in = 1'b1;
                  phase_in      = (marker_word[30:0] != '0) ? PH_BODY : PH_MARKER;
               end
            end else begin
               record_total_in = total_sum[30:0];
               if (marker_word[30:0] != '0) begin
                  phase_in = PH_BODY;
               end else if (marker_word[31]) begin
                  res_valid = 1'b1;
                  res.last  = 1'b1;
                  if (field_index_ff >= F_ARGS) begin
                     res.kind = KIND_EMPTY_END;
                  end else begin
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_MALFORMED;
                  end
                  end_rec = 1'b1;
               end
            end
         end
      end else begin
         fragment_left_in = frag_dec;
         if (frag_dec == '0) begin
            phase_in = PH_MARKER;
         end
         if (discarding_ff) begin
            end_rec = ends;
         end else begin
            case (pres)
               PR_ERROR: begin
                  res_valid = 1'b1;
                  res       = pout;
                  if (ends) begin
                     end_rec = 1'b1;
                  end else begin
                     discarding_in = 1'b1;
                  end
               end
               PR_DATA: begin
                  res_valid = 1'b1;
                  res       = pout;
                  res.last  = ends;
                  end_rec   = ends;
               end
               default: begin
                  if (ends) begin
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.last       = 1'b1;
                     res.error_code = ERR_MALFORMED;
                     end_rec        = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_MARKER;
         marker_shift_ff   <= '0;
         marker_count_ff   <= '0;
         fragment_left_ff  <= '0;
         final_fragment_ff <= 1'b0;
         record_total_ff   <= '0;
         word_shift_ff     <= '0;
         byte_in_word_ff   <= '0;
         field_index_ff    <= F_XID;
         opaque_left_ff    <= '0;
         discarding_ff     <= 1'b0;
      end else if (step_en) begin
         if (end_rec) begin
            phase_ff          <= PH_MARKER;
            marker_shift_ff   <= '0;
            marker_count_ff   <= '0;
            fragment_left_ff  <= '0;
            final_fragment_ff <= 1'b0;
            record_total_ff   <= '0;
            word_shift_ff     <= '0;
            byte_in_word_ff   <= '0;
            field_index_ff    <= F_XID;
            opaque_left_ff    <= '0;
            discarding_ff     <= 1'b0;
         end else begin
            phase_ff          <= phase_in;
            marker_shift_ff   <= marker_shift_in;
            marker_count_ff   <= marker_count_in;
            fragment_left_ff  <= fragment_left_in;
            final_fragment_ff <= final_fragment_in;
            record_total_ff   <= record_total_in;
            discarding_ff     <= discarding_in;
            if (phase_ff == PH_BODY && !discarding_ff) begin
               word_shift_ff   <= word_shift_in;
               byte_in_word_ff <= byte_in_word_in;
               field_index_ff  <= field_index_in;
               opaque_left_ff  <= opaque_left_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && phase_ff == PH_BODY && !discarding_ff) begin
         xid_ff       <= xid_in;
         program_ff   <= program_in;
         version_ff   <= version_in;
         procedure_ff <= procedure_in;
      end
   end

endmodule

FILE: hdl/rpc_record_call_header_parser_core.sv
// ----------------------------------------------------------------------------
// rpc_record_call_header_parser_core
// Record-marked RPC call header parser: one transport byte per request,
// header, argument, error and end-of-record results on the response channel.
// ----------------------------------------------------------------------------
// Latency: a result is presented the cycle after its request is accepted.
// Throughput: one request per cycle, set by the single parse pass between
// the request handshake and the response register, unless a held response is not taken.
// Reset (synchronous): parse state cleared, response empty,
// max_record_bytes back to 1048576.
// ----------------------------------------------------------------------------
module rpc_record_call_header_parser_core #(
   parameter int MAX_AUTH_BODY = 400
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_xid,
   output logic [31:0] rsp_program_res,
   output logic [31:0] rsp_prog_version,
   output logic [31:0] rsp_procedure,
   output logic [7:0]  rsp_arg_byte,
   output logic        rsp_last,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data
);
   import rpchdr_pkg::*;

   logic        accept;
   logic        res_valid;
   rsp_type     res;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [30:0] max_record_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   rpchdr_parse #(
      .MAX_AUTH_BODY (MAX_AUTH_BODY)
   ) u_parse (
      .clock            (clock),
      .reset            (reset),
      .step_en          (accept),
      .data_byte        (req_data_byte),
      .max_record_bytes (max_record_ff),
      .res_valid        (res_valid),
      .res              (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         max_record_ff <= MAX_RECORD_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_record_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_xid          = rsp_ff.xid;
   assign rsp_program_res  = rsp_ff.program_res;
   assign rsp_prog_version = rsp_ff.prog_version;
   assign rsp_procedure    = rsp_ff.procedure;
   assign rsp_arg_byte     = rsp_ff.arg_byte;
   assign rsp_last         = rsp_ff.last;
   assign rsp_error_code   = rsp_ff.error_code;

endmodule
